// ===== sv/dosf_pkg.sv =====
// Package for the drop-oldest sample FIFO: parameter defaults, opcodes, status codes
// and the result struct passed from the control block to the output stage.
// Depends on nothing.
package dosf_pkg;

  localparam int FIFO_DEPTH_DEF   = 16;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int TOTAL_W          = 32;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // Result fields whose widths do not depend on parameters
  typedef struct packed {
    status_e              status;
    logic                 pop_ok;
    logic [TOTAL_W-1:0]   push_total;
    logic [TOTAL_W-1:0]   pop_total;
    logic [TOTAL_W-1:0]   overflow_total;
  } res_t;

endpackage

// ===== sv/dosf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dosf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dosf_ctrl.sv =====
// Pointer, fill-level and counter update for the drop-oldest sample FIFO.
// Depends on dosf_pkg; drives the write and read ports of dosf_ram.
module dosf_ctrl #(
  parameter int FIFO_DEPTH = dosf_pkg::FIFO_DEPTH_DEF,
  localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  dosf_pkg::op_e       op_i,
  output logic                ram_we_o,
  output logic [PTR_W-1:0]    ram_waddr_o,
  output logic                ram_re_o,
  output logic [PTR_W-1:0]    ram_raddr_o,
  output dosf_pkg::res_t      res_o,
  output logic [CNT_W-1:0]    fill_o,
  output logic [CNT_W-1:0]    peak_o
);

  localparam logic [PTR_W-1:0] LastSlot = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] FullCnt  = CNT_W'(FIFO_DEPTH);

  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, peak_q, peak_d;
  logic [dosf_pkg::TOTAL_W-1:0] push_q, push_d, pop_q, pop_d, drop_q, drop_d;
  dosf_pkg::status_e status;
  logic pop_ok;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
    return (slot == LastSlot) ? '0 : slot + 1'b1;
  endfunction

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    cnt_d  = cnt_q;
    peak_d = peak_q;
    push_d = push_q;
    pop_d  = pop_q;
    drop_d = drop_q;
    status = dosf_pkg::ST_OK;
    pop_ok = 1'b0;
    case (op_i)
      dosf_pkg::OP_PUSH: begin
        if (cnt_q == FullCnt) begin
          // drop the oldest entry; the level stays at full
          rd_d   = next_slot(rd_q);
          drop_d = drop_q + 1'b1;
          status = dosf_pkg::ST_OVERFLOW;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
        wr_d   = next_slot(wr_q);
        push_d = push_q + 1'b1;
        if (cnt_d > peak_q) begin
          peak_d = cnt_d;
        end
      end
      dosf_pkg::OP_POP: begin
        if (cnt_q == '0) begin
          status = dosf_pkg::ST_EMPTY;
        end else begin
          rd_d   = next_slot(rd_q);
          cnt_d  = cnt_q - 1'b1;
          pop_d  = pop_q + 1'b1;
          pop_ok = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      peak_q <= '0;
      push_q <= '0;
      pop_q  <= '0;
      drop_q <= '0;
    end else if (accept_i) begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      cnt_q  <= cnt_d;
      peak_q <= peak_d;
      push_q <= push_d;
      pop_q  <= pop_d;
      drop_q <= drop_d;
    end
  end

  assign ram_we_o    = accept_i && (op_i == dosf_pkg::OP_PUSH);
  assign ram_waddr_o = wr_q;
  // read the head on every request; only a successful pop uses the data
  assign ram_re_o    = accept_i;
  assign ram_raddr_o = rd_q;

  assign res_o.status         = status;
  assign res_o.pop_ok         = pop_ok;
  assign res_o.push_total     = push_d;
  assign res_o.pop_total      = pop_d;
  assign res_o.overflow_total = drop_d;
  assign fill_o               = cnt_d;
  assign peak_o               = peak_d;

endmodule

// ===== sv/dosf_out.sv =====
// Result register and output stream packing for the drop-oldest sample FIFO.
// Depends on dosf_pkg; takes the registered read data of dosf_ram.
module dosf_out #(
  parameter int FIFO_DEPTH   = dosf_pkg::FIFO_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = dosf_pkg::SAMPLE_WIDTH_DEF,
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1),
  localparam int FIELDS_W    = SAMPLE_WIDTH + 2 * CNT_W + 3 * dosf_pkg::TOTAL_W,
  localparam int TDATA_W     = ((FIELDS_W + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  dosf_pkg::res_t          res_i,
  input  logic [CNT_W-1:0]        fill_i,
  input  logic [CNT_W-1:0]        peak_i,
  input  logic [SAMPLE_WIDTH-1:0] rdata_i,
  output logic                    in_ready_o,
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [TDATA_W-1:0]      m_axis_tdata_o,
  output logic [1:0]              m_axis_tuser_o
);

  logic                 valid_q, valid_d;
  dosf_pkg::res_t       res_q;
  logic [CNT_W-1:0]     fill_q, peak_q;
  logic [SAMPLE_WIDTH-1:0] sample;

  // take a new request when the slot is empty or is drained this cycle
  assign in_ready_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q  <= res_i;
      fill_q <= fill_i;
      peak_q <= peak_i;
    end
  end

  // RAM read data loads on the same edge and holds until the next request
  assign sample = res_q.pop_ok ? rdata_i : '0;

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tuser_o  = res_q.status;
  assign m_axis_tdata_o  = TDATA_W'({res_q.overflow_total, res_q.pop_total,
                                     res_q.push_total, peak_q, fill_q, sample});

endmodule

// ===== sv/drop_oldest_sample_fifo_core.sv =====
// Top level of the drop-oldest sample FIFO.
// Depends on dosf_pkg, dosf_ram, dosf_ctrl and dosf_out.

// Each request is a push or a pop and yields exactly one result, valid in the cycle after it
// is taken; one request is taken every clock cycle while results are drained. s_axis_tready_o
// is high whenever the result register is empty or is being read in the same cycle. The
// pointers and counters are registered and update beside one sample RAM with one write and
// one registered read port; the popped sample comes straight from that read register.
// A push into a full FIFO drops the oldest sample and reports overflow. The sample store
// needs no clearing after reset: only written entries are ever popped.
module drop_oldest_sample_fifo_core #(
  parameter int FIFO_DEPTH   = dosf_pkg::FIFO_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = dosf_pkg::SAMPLE_WIDTH_DEF,
  localparam int PTR_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1),
  localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_FIELDS_W = SAMPLE_WIDTH + 2 * CNT_W + 3 * dosf_pkg::TOTAL_W,
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // sample_in
  input  logic                   s_axis_tuser_i,  // op
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // sample_out, fill_level, peak_level, push_total, pop_total, overflow_total
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]             m_axis_tuser_o   // status
);

  logic                    accept;
  logic                    ram_we, ram_re;
  logic [PTR_W-1:0]        ram_waddr, ram_raddr;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;
  dosf_pkg::res_t          res;
  logic [CNT_W-1:0]        fill, peak;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  dosf_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (dosf_pkg::op_e'(s_axis_tuser_i)),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .res_o       (res),
    .fill_o      (fill),
    .peak_o      (peak)
  );

  dosf_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata_i[SAMPLE_WIDTH-1:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dosf_out #(
    .FIFO_DEPTH   (FIFO_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .res_i           (res),
    .fill_i          (fill),
    .peak_i          (peak),
    .rdata_i         (ram_rdata),
    .in_ready_o      (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== sv/dosf_chk.sv =====
// Port-level checker for the drop-oldest sample FIFO, bound to the top level.
// Depends on dosf_pkg and drop_oldest_sample_fifo_core.
module dosf_chk #(
  parameter int FIFO_DEPTH   = dosf_pkg::FIFO_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = dosf_pkg::SAMPLE_WIDTH_DEF,
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1),
  localparam int OUT_FIELDS_W = SAMPLE_WIDTH + 2 * CNT_W + 3 * dosf_pkg::TOTAL_W,
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]             m_axis_tuser_o
);

  logic [SAMPLE_WIDTH-1:0] sample;
  logic [CNT_W-1:0]        fill, peak;

  assign sample = m_axis_tdata_o[SAMPLE_WIDTH-1:0];
  assign fill   = m_axis_tdata_o[SAMPLE_WIDTH +: CNT_W];
  assign peak   = m_axis_tdata_o[SAMPLE_WIDTH + CNT_W +: CNT_W];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted request gave no result");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == dosf_pkg::ST_EMPTY |-> sample == '0 && fill == '0)
    else $error("empty pop with data or nonzero level");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == dosf_pkg::ST_OVERFLOW |-> fill == CNT_W'(FIFO_DEPTH))
    else $error("overflow reported below full level");

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> fill <= peak && peak <= CNT_W'(FIFO_DEPTH))
    else $error("fill level above peak or depth");

endmodule

bind drop_oldest_sample_fifo_core dosf_chk #(
  .FIFO_DEPTH   (FIFO_DEPTH),
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dosf_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== tb/dosf_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the drop-oldest sample FIFO: watches both stream channels,
// models the FIFO per accepted request and compares every result field.
// Depends on dosf_pkg.
module dosf_result_checker #(
  parameter int TDATA_W = 144
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  logic               s_ready_i,
  input  logic [31:0]        s_data_i,
  input  logic               s_user_i,
  input  logic               m_valid_i,
  input  logic               m_ready_i,
  input  logic [TDATA_W-1:0] m_data_i,
  input  logic [1:0]         m_user_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 drops_o,
  output int                 empties_o,
  output int                 peak_o
);

  localparam int DEPTH      = dosf_pkg::FIFO_DEPTH_DEF;
  localparam int FILL_LSB   = 32;
  localparam int PEAK_LSB   = 37;
  localparam int PUSH_LSB   = 42;
  localparam int POP_LSB    = 74;
  localparam int DROP_LSB   = 106;
  localparam int FIELDS_END = 138;

  typedef struct packed {
    dosf_pkg::status_e status;
    logic [31:0] sample;
    logic [4:0]  fill;
    logic [4:0]  peak;
    logic [31:0] pushes;
    logic [31:0] pops;
    logic [31:0] drops;
  } fifo_result_t;

  logic [31:0]  sample_mem [DEPTH];
  logic [3:0]   wr_slot;
  logic [3:0]   rd_slot;
  logic [4:0]   held;
  logic [4:0]   held_peak;
  logic [31:0]  push_cnt;
  logic [31:0]  pop_cnt;
  logic [31:0]  drop_cnt;
  fifo_result_t expected_results [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    drops_o      = 0;
    empties_o    = 0;
    peak_o       = 0;
  end

  // Apply one request to the FIFO image and return the result it must produce
  function automatic fifo_result_t advance_fifo_model(dosf_pkg::op_e op, logic [31:0] smp);
    fifo_result_t res;
    res        = '0;
    res.status = dosf_pkg::ST_OK;
    if (op == dosf_pkg::OP_PUSH) begin
      if (held == DEPTH) begin
        // drop the oldest entry before storing
        rd_slot    = rd_slot + 4'd1;
        held       = held - 5'd1;
        drop_cnt   = drop_cnt + 32'd1;
        res.status = dosf_pkg::ST_OVERFLOW;
      end
      sample_mem[wr_slot] = smp;
      wr_slot  = wr_slot + 4'd1;
      held     = held + 5'd1;
      push_cnt = push_cnt + 32'd1;
      if (held > held_peak) held_peak = held;
    end else if (held == 0) begin
      res.status = dosf_pkg::ST_EMPTY;
    end else begin
      res.sample = sample_mem[rd_slot];
      rd_slot    = rd_slot + 4'd1;
      held       = held - 5'd1;
      pop_cnt    = pop_cnt + 32'd1;
    end
    res.fill   = held;
    res.peak   = held_peak;
    res.pushes = push_cnt;
    res.pops   = pop_cnt;
    res.drops  = drop_cnt;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] result %0d: %s mismatch, got 0x%0h, expected 0x%0h",
             $realtime, checked_o, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fifo_result_t want;
    if (!rst_ni) begin
      wr_slot   = '0;
      rd_slot   = '0;
      held      = '0;
      held_peak = '0;
      push_cnt  = '0;
      pop_cnt   = '0;
      drop_cnt  = '0;
      expected_results.delete();
    end else begin
      if (m_valid_i && m_ready_i) begin
        checked_o++;
        if (expected_results.size() == 0) begin
          report_mismatch("unrequested result", m_data_i[31:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (m_user_i !== want.status)
            report_mismatch("status", m_user_i, want.status);
          if (m_data_i[31:0] !== want.sample)
            report_mismatch("sample_out", m_data_i[31:0], want.sample);
          if (m_data_i[FILL_LSB +: 5] !== want.fill)
            report_mismatch("fill_level", m_data_i[FILL_LSB +: 5], want.fill);
          if (m_data_i[PEAK_LSB +: 5] !== want.peak)
            report_mismatch("peak_level", m_data_i[PEAK_LSB +: 5], want.peak);
          if (m_data_i[PUSH_LSB +: 32] !== want.pushes)
            report_mismatch("push_total", m_data_i[PUSH_LSB +: 32], want.pushes);
          if (m_data_i[POP_LSB +: 32] !== want.pops)
            report_mismatch("pop_total", m_data_i[POP_LSB +: 32], want.pops);
          if (m_data_i[DROP_LSB +: 32] !== want.drops)
            report_mismatch("overflow_total", m_data_i[DROP_LSB +: 32], want.drops);
          if (m_data_i[TDATA_W-1:FIELDS_END] !== '0)
            report_mismatch("tdata padding", m_data_i[TDATA_W-1:FIELDS_END], '0);
        end
      end
      if (s_valid_i && s_ready_i) begin
        want = advance_fifo_model(dosf_pkg::op_e'(s_user_i), s_data_i);
        if (want.status == dosf_pkg::ST_EMPTY) empties_o++;
        expected_results.push_back(want);
      end
      pending_o = expected_results.size();
      drops_o   = drop_cnt;
      peak_o    = held_peak;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the drop-oldest sample FIFO testbench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict.
// Depends on dosf_pkg, drop_oldest_sample_fifo_core and dosf_result_checker.
module testbench;

  localparam int OUT_W        = 144;
  localparam int RANDOM_ITEMS = 500;
  localparam int IDLE_LIMIT   = 2000;

  logic             clk_i = 1'b0;
  logic             rst_n = 1'b0;
  logic             s_valid = 1'b0;
  logic             s_ready;
  logic [31:0]      s_data = '0;
  logic             s_user = 1'b0;
  logic             m_valid;
  logic             m_ready = 1'b0;
  logic [OUT_W-1:0] m_data;
  logic [1:0]       m_user;

  int fail_count;
  int pending;
  int checked;
  int drops;
  int empties;
  int peak;
  int requests_sent = 0;
  int idle_cycles = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  always #1 clk_i = ~clk_i;

  drop_oldest_sample_fifo_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  dosf_result_checker #(.TDATA_W(OUT_W)) u_result_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .s_user_i     (s_user),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .m_user_i     (m_user),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .drops_o      (drops),
    .empties_o    (empties),
    .peak_o       (peak)
  );

  // Hold valid until the request is taken; idle a random gap first unless in a steady run
  task automatic send_request(dosf_pkg::op_e op, logic [31:0] smp);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= smp;
    do @(posedge clk_i); while (!s_ready);
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Result side: random stalls, with steady stretches now and then
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_valid);
    end
  end

  // Abort when the channels stop moving
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results pending",
               IDLE_LIMIT, pending);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int directed_cnt;
    int random_cnt;
    int run_len;
    int push_pct;
    bit drained;
    dosf_pkg::op_e op;
    drained = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: pop on empty, extreme samples, fill past full, partial drain
    send_request(dosf_pkg::OP_POP, 32'hFFFF_FFFF);
    send_request(dosf_pkg::OP_PUSH, 32'h0000_0000);
    send_request(dosf_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_request(dosf_pkg::OP_POP, 32'h0000_0000);
    send_request(dosf_pkg::OP_POP, 32'hFFFF_FFFF);
    send_request(dosf_pkg::OP_POP, 32'h1234_5678);
    for (int i = 0; i < 17; i++)
      send_request(dosf_pkg::OP_PUSH, (i % 2) ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ i);
    send_request(dosf_pkg::OP_POP, 32'h0);
    send_request(dosf_pkg::OP_POP, 32'h0);
    directed_cnt = requests_sent;

    // Random runs, each biased toward filling, draining or a balanced mix
    random_cnt = 0;
    while (random_cnt < RANDOM_ITEMS) begin
      run_len = $urandom_range(1, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      tx_steady = ($urandom_range(0, 3) == 0);
      repeat (run_len) begin
        op = ($urandom_range(0, 99) < push_pct) ? dosf_pkg::OP_PUSH : dosf_pkg::OP_POP;
        send_request(op, $urandom);
        random_cnt++;
      end
      if (!drained && random_cnt >= RANDOM_ITEMS / 2) begin
        wait_for_drain();
        drained = 1'b1;
      end
    end

    wait_for_drain();
    repeat (4) @(posedge clk_i);

    $display("Sent %0d requests (%0d directed), checked %0d results",
             requests_sent, directed_cnt, checked);
    $display("Peak fill %0d, %0d oldest-entry drops, %0d pops on empty",
             peak, drops, empties);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
